// ===== rtl/tmsf_pkg.sv =====
package tmsf_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int AVG_W    = 12;

  // Filter shape
  localparam int WINDOW_SIZE = 100;
  localparam int KEEP_START  = 40;
  localparam int KEEP_COUNT  = 20;
  localparam int ROUNDS      = 20;

  // Index into the sorted window
  localparam int IDX_W = $clog2(WINDOW_SIZE);

  // Kept ranks, clipped to the window
  localparam bit KEEP_NONE  = (KEEP_START >= WINDOW_SIZE);
  localparam int KEEP_END   = (KEEP_START + KEEP_COUNT > WINDOW_SIZE) ?
                              WINDOW_SIZE : KEEP_START + KEEP_COUNT;
  localparam int KEEP_FIRST = KEEP_NONE ? 0 : KEEP_START;
  localparam int KEEP_LAST  = KEEP_NONE ? 0 : KEEP_END - 1;

  // Arithmetic widths
  localparam int SUM_W  = SAMPLE_W + $clog2(KEEP_COUNT);
  localparam int ACC_W  = SAMPLE_W + $clog2(ROUNDS);
  localparam int DIV_W  = (SUM_W > ACC_W) ? SUM_W : ACC_W;
  localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  // Division by a constant d: floor(x / d) = (x * ceil(2^s / d)) >> s,
  // exact for any x below 2^DIV_W when s = DIV_W + clog2(d)
  localparam int RECIP_W    = DIV_W + 1;
  localparam int PROD_W     = DIV_W + RECIP_W;
  localparam int MEAN_SHIFT = DIV_W + $clog2(KEEP_COUNT);
  localparam int AVG_SHIFT  = DIV_W + $clog2(ROUNDS);
  localparam longint MEAN_RECIP =
    ((longint'(1) << MEAN_SHIFT) + longint'(KEEP_COUNT) - 1) / longint'(KEEP_COUNT);
  localparam longint AVG_RECIP =
    ((longint'(1) << AVG_SHIFT) + longint'(ROUNDS) - 1) / longint'(ROUNDS);

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch accepted beat, start insertion
    logic shift;      // one insertion step
    logic sum_start;  // clear trimmed sum, point at first kept rank
    logic sum_step;   // read next kept rank
    logic div_mean;   // start window mean division
    logic acc_add;    // add window mean to accumulator
    logic emit;       // load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ins_done;   // insertion finishes this cycle
    logic win_full;   // this sample completes the window
    logic rank_last;  // last kept rank being read
    logic round_last; // this window completes the run
    logic div_busy;   // divider running
    logic out_free;   // output register can take a result
  } status_t;

endpackage

// ===== rtl/trimmed_mean_sample_filter.sv =====
// Trimmed-mean sample filter.
// Input channel: in_valid/in_ready with in_sample (12 bits) and in_channel.
// Each beat is insertion-sorted into a 100-entry window memory, walking
// down from the top one compare-and-move per cycle, so a sample moves
// k stored entries up one slot, k being the number of stored entries
// larger than it (0 to 99).
// When the window fills, ranks 40..59 are read and summed, the sum is divided
// by 20 with a reciprocal multiply, and that mean is added to an accumulator.
// After 20 windows the accumulator is divided the same way and the result is
// placed in the output register after the last sample's final insertion step.
// Output channel: out_valid/out_ready with out_average and out_channel_out
// (channel of the run's final sample). The output register lets the block
// keep accepting samples while a result waits; only a second result
// stalls, in front of the output register, until the first is taken.
// Reset (rst_n low, synchronous) clears the window fill, round count,
// accumulator and any pending result. The window memory needs no clear.
module trimmed_mean_sample_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tmsf_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                           in_channel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tmsf_pkg::AVG_W-1:0]     out_average,
  output logic                           out_channel_out
);

  tmsf_pkg::cmd_t    cmd;
  tmsf_pkg::status_t status;

  tmsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tmsf_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample       (in_sample),
    .in_channel      (in_channel),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_average     (out_average),
    .out_channel_out (out_channel_out)
  );

  // One sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a beat while an insertion was running");

  // No sample taken while a division runs
  a_no_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && status.div_busy))
    else $error("input ready during division");

  // A result never overwrites one that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  // Insertion steps happen only with no divider activity
  a_shift_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> (!status.div_busy && !cmd.emit))
    else $error("insertion overlapped the window-end work");

endmodule

// ===== rtl/tmsf_ctrl.sv =====
module tmsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmsf_pkg::status_t status,
  output tmsf_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_SUM_TAIL,
    ST_DIV_MEAN,
    ST_DIV_AVG,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.ins_done) begin
          if (status.win_full) begin
            cmd.sum_start = 1'b1;
            state_nxt     = tmsf_pkg::KEEP_NONE ? ST_SUM_TAIL : ST_SUM;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.rank_last) begin
          state_nxt = ST_SUM_TAIL;
        end
      end
      ST_SUM_TAIL: begin
        cmd.div_mean = 1'b1;
        state_nxt    = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        if (!status.div_busy) begin
          cmd.acc_add = 1'b1;
          state_nxt   = status.round_last ? ST_DIV_AVG : ST_IDLE;
        end
      end
      ST_DIV_AVG: begin
        if (!status.div_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/tmsf_dpath.sv =====
module tmsf_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tmsf_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                            in_channel,
  input  tmsf_pkg::cmd_t                  cmd,
  output tmsf_pkg::status_t               status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tmsf_pkg::AVG_W-1:0]      out_average,
  output logic                            out_channel_out
);

  localparam int SW  = tmsf_pkg::SAMPLE_W;
  localparam int IW  = tmsf_pkg::IDX_W;
  localparam int DW  = tmsf_pkg::DIV_W;
  localparam int RW  = tmsf_pkg::RECIP_W;
  localparam int PW  = tmsf_pkg::PROD_W;

  // Sorted window, kept in ascending order as samples arrive
  logic [SW-1:0] sort_mem [tmsf_pkg::WINDOW_SIZE];
  logic [SW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  logic [SW-1:0] new_r;
  logic          chan_r;
  logic [IW-1:0] pos_r;
  logic [IW-1:0] count_r;
  logic [IW-1:0] rank_r;
  logic          add_en_r;

  logic [tmsf_pkg::SUM_W-1:0] sum_r;
  logic [tmsf_pkg::SUM_W-1:0] sum_nxt;
  logic [tmsf_pkg::ACC_W-1:0] acc_r;
  logic [tmsf_pkg::ACC_W-1:0] acc_plus;
  logic [tmsf_pkg::RND_W-1:0] round_r;

  // Divider
  logic          div_busy_r;
  logic [DW-1:0] dvd_r;
  logic          den_sel_r;   // 0: keep count, 1: rounds
  logic [RW-1:0] recip;
  logic [PW-1:0] prod;
  logic [DW-1:0] quot;

  logic out_valid_r;
  logic [tmsf_pkg::AVG_W-1:0] out_avg_r;
  logic out_ch_r;

  logic start_avg;

  // Status
  assign status.ins_done   = (pos_r == '0) || (rd_data_r <= new_r);
  assign status.win_full   = (count_r == IW'(tmsf_pkg::WINDOW_SIZE - 1));
  assign status.rank_last  = (rank_r == IW'(tmsf_pkg::KEEP_LAST));
  assign status.round_last = (round_r == tmsf_pkg::RND_W'(tmsf_pkg::ROUNDS - 1));
  assign status.div_busy   = div_busy_r;
  assign status.out_free   = !out_valid_r || out_ready;

  // Read address: predecessor of the insertion slot, or a kept rank
  always_comb begin
    if (cmd.load) begin
      rd_addr = (count_r == '0) ? '0 : count_r - IW'(1);
    end else if (cmd.sum_step) begin
      rd_addr = rank_r;
    end else begin
      rd_addr = (pos_r >= IW'(2)) ? pos_r - IW'(2) : '0;
    end
  end

  // Write: move a larger entry up one slot, or drop the new sample in
  assign wr_en   = cmd.shift;
  assign wr_addr = pos_r;
  assign wr_data = status.ins_done ? new_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sort_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= sort_mem[rd_addr];
  end

  // Insertion pointer and window fill
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_r  <= in_sample;
      chan_r <= in_channel;
      pos_r  <= count_r;
    end else if (cmd.shift && !status.ins_done) begin
      pos_r <= pos_r - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.shift && status.ins_done) begin
      count_r <= status.win_full ? '0 : count_r + IW'(1);
    end
  end

  // Trimmed sum over kept ranks; read data is registered and is added in the cycle after its read
  assign sum_nxt = cmd.sum_start ? '0 :
                   add_en_r ? sum_r + tmsf_pkg::SUM_W'(rd_data_r) : sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_en_r <= 1'b0;
    end else begin
      add_en_r <= cmd.sum_step;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (cmd.sum_start) begin
      rank_r <= IW'(tmsf_pkg::KEEP_FIRST);
    end else if (cmd.sum_step) begin
      rank_r <= rank_r + IW'(1);
    end
  end

  // Run accumulator
  assign acc_plus  = acc_r + tmsf_pkg::ACC_W'(dvd_r[SW-1:0]);
  assign start_avg = cmd.acc_add && status.round_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      round_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r   <= status.round_last ? '0 : acc_plus;
      round_r <= status.round_last ? '0 : round_r + tmsf_pkg::RND_W'(1);
    end
  end

  // Division by a constant: reciprocal multiply; the dividend is registered and the quotient is written back over it
  assign recip = den_sel_r ? RW'(tmsf_pkg::AVG_RECIP) : RW'(tmsf_pkg::MEAN_RECIP);
  assign prod  = PW'(dvd_r) * PW'(recip);
  assign quot  = den_sel_r ? DW'(prod >> tmsf_pkg::AVG_SHIFT) :
                             DW'(prod >> tmsf_pkg::MEAN_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_mean || start_avg) begin
      div_busy_r <= 1'b1;
    end else begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_mean) begin
      dvd_r     <= DW'(sum_nxt);
      den_sel_r <= 1'b0;
    end else if (start_avg) begin
      dvd_r     <= DW'(acc_plus);
      den_sel_r <= 1'b1;
    end else if (div_busy_r) begin
      dvd_r <= quot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_avg_r <= dvd_r[tmsf_pkg::AVG_W-1:0];
      out_ch_r  <= chan_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = out_avg_r;
  assign out_channel_out = out_ch_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLE_MAX  = (1 << tmsf_pkg::SAMPLE_W) - 1;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int RUNS_PER_PHASE = 6;
  localparam int REPORT_MAX  = 10;
  localparam int NUM_PHASES  = 4;
  localparam int SRC_IDLE   [NUM_PHASES] = '{0, 52, 0, 18};
  localparam int SINK_STALL [NUM_PHASES] = '{0, 0, 52, 18};

  // How the samples of one window are laid out
  typedef enum logic [2:0] {
    SHAPE_CONST,   // every sample a
    SHAPE_SPLIT,   // first half a, second half b
    SHAPE_RAMP,    // a + pos*b, clipped
    SHAPE_DESC,    // a - pos*b, clipped: worst case for the insertion sort
    SHAPE_BAND,    // uniform between a and b
    SHAPE_LEVELS   // random pick of a or b
  } win_shape_t;

  // One run of ROUNDS windows: window 0 uses the first shape, the rest the other
  typedef struct packed {
    win_shape_t     first_shape;
    int             first_a;
    int             first_b;
    win_shape_t     rest_shape;
    int             rest_a;
    int             rest_b;
    bit             mixed;      // random channel on all but the final beat
    bit             last_ch;    // channel of the final beat
    bit             typed;      // expected average given in the table
    logic [tmsf_pkg::AVG_W-1:0] typed_avg;
  } run_plan_t;

  typedef struct packed {
    logic [tmsf_pkg::AVG_W-1:0] average;
    logic                       channel_out;
  } avg_result_t;

  // Directed runs
  localparam int NUM_DIRECTED = 8;
  localparam run_plan_t DIRECTED_RUNS [NUM_DIRECTED] = '{
    '{SHAPE_CONST, 0, 0, SHAPE_CONST, 0, 0, 1'b0, 1'b0, 1'b1, 12'd0},
    '{SHAPE_CONST, 4095, 0, SHAPE_CONST, 4095, 0, 1'b0, 1'b1, 1'b1, 12'd4095},
    '{SHAPE_SPLIT, 0, 4095, SHAPE_SPLIT, 0, 4095, 1'b0, 1'b0, 1'b1, 12'd2047},
    '{SHAPE_RAMP, 0, 1, SHAPE_RAMP, 0, 1, 1'b0, 1'b1, 1'b1, 12'd49},
    '{SHAPE_CONST, 4095, 0, SHAPE_CONST, 0, 0, 1'b0, 1'b0, 1'b1, 12'd204},
    '{SHAPE_CONST, 1234, 0, SHAPE_CONST, 1234, 0, 1'b1, 1'b0, 1'b1, 12'd1234},
    '{SHAPE_CONST, 2222, 0, SHAPE_CONST, 2222, 0, 1'b1, 1'b1, 1'b1, 12'd2222},
    '{SHAPE_DESC, 4095, 41, SHAPE_RAMP, 100, 7, 1'b0, 1'b1, 1'b0, 12'd0}
  };

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [tmsf_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                          in_channel = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [tmsf_pkg::AVG_W-1:0]    out_average;
  logic                          out_channel_out;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  // Predictor state
  logic [tmsf_pkg::SAMPLE_W-1:0] win_buf [tmsf_pkg::WINDOW_SIZE];
  int                            fill_cnt = 0;
  int                            round_cnt = 0;
  logic [tmsf_pkg::ACC_W-1:0]    mean_acc = '0;

  avg_result_t avg_expect_q [$];
  bit          typed_pending = 1'b0;
  avg_result_t typed_value = '0;

  trimmed_mean_sample_filter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_channel      (in_channel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_average     (out_average),
    .out_channel_out (out_channel_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sort a copy of the window and average the kept ranks
  function automatic logic [tmsf_pkg::SAMPLE_W-1:0] window_trimmed_mean();
    logic [tmsf_pkg::SAMPLE_W-1:0] ranked [tmsf_pkg::WINDOW_SIZE];
    logic [tmsf_pkg::SAMPLE_W-1:0] v;
    int                            j;
    int unsigned                   rank_sum;
    ranked = win_buf;
    rank_sum = 0;
    for (int i = 1; i < tmsf_pkg::WINDOW_SIZE; i++) begin
      v = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    // ranks past the window end add nothing; the divisor stays
    for (int r = tmsf_pkg::KEEP_START; r < tmsf_pkg::KEEP_START + tmsf_pkg::KEEP_COUNT;
         r++) begin
      if (r < tmsf_pkg::WINDOW_SIZE) rank_sum += ranked[r];
    end
    return tmsf_pkg::SAMPLE_W'(rank_sum / tmsf_pkg::KEEP_COUNT);
  endfunction

  // Advance the predictor by one accepted beat
  task automatic predict_beat(input logic [tmsf_pkg::SAMPLE_W-1:0] s, input logic ch,
                              output bit made, output avg_result_t res);
    made = 1'b0;
    res = '0;
    win_buf[fill_cnt] = s;
    fill_cnt++;
    if (fill_cnt == tmsf_pkg::WINDOW_SIZE) begin
      fill_cnt = 0;
      mean_acc += window_trimmed_mean();
      round_cnt++;
      if (round_cnt == tmsf_pkg::ROUNDS) begin
        res.average = tmsf_pkg::AVG_W'(mean_acc / tmsf_pkg::ROUNDS);
        res.channel_out = ch;
        made = 1'b1;
        mean_acc = '0;
        round_cnt = 0;
      end
    end
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  // Predict on input beats, check output beats
  always @(posedge clk) begin : result_check
    avg_result_t got;
    avg_result_t want;
    avg_result_t pred;
    bit          made;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_beat(in_sample, in_channel, made, pred);
        if (made) avg_expect_q.push_back(typed_pending ? typed_value : pred);
      end
      if (out_valid && out_ready) begin
        got.average = out_average;
        got.channel_out = out_channel_out;
        if (avg_expect_q.size() == 0) begin
          flag_error($sformatf("unexpected result beat: average %0d channel %0d",
                               got.average, got.channel_out));
        end else begin
          want = avg_expect_q.pop_front();
          if (got.average !== want.average)
            flag_error($sformatf("average mismatch: expected %0d, got %0d",
                                 want.average, got.average));
          if (got.channel_out !== want.channel_out)
            flag_error($sformatf("channel mismatch: expected %0d, got %0d",
                                 want.channel_out, got.channel_out));
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Sample value at a given position of a window
  function automatic logic [tmsf_pkg::SAMPLE_W-1:0] window_value(input win_shape_t shape,
                                                                 input int a, input int b,
                                                                 input int pos);
    int v;
    case (shape)
      SHAPE_CONST:  v = a;
      SHAPE_SPLIT:  v = (pos < tmsf_pkg::WINDOW_SIZE / 2) ? a : b;
      SHAPE_RAMP:   v = a + pos * b;
      SHAPE_DESC:   v = a - pos * b;
      SHAPE_BAND:   v = $urandom_range(a, b);
      default:      v = $urandom_range(1) ? a : b;
    endcase
    if (v < 0) v = 0;
    else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return tmsf_pkg::SAMPLE_W'(v);
  endfunction

  // Drive one beat; entered and left at a falling edge, valid left high
  task automatic push_sample(input logic [tmsf_pkg::SAMPLE_W-1:0] s, input logic ch);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_channel <= ch;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold off until every expected result has been taken
  task automatic wait_drain();
    while (avg_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic drive_window(input win_shape_t shape, input int a, input int b,
                              input bit mixed, input bit last_ch, input bit closes_run);
    logic [tmsf_pkg::SAMPLE_W-1:0] s;
    logic                          ch;
    for (int pos = 0; pos < tmsf_pkg::WINDOW_SIZE; pos++) begin
      s = window_value(shape, a, b, pos);
      ch = mixed ? logic'($urandom_range(1)) : last_ch;
      if (closes_run && pos == tmsf_pkg::WINDOW_SIZE - 1) ch = last_ch;
      push_sample(s, ch);
    end
  endtask

  task automatic drive_run(input run_plan_t plan);
    typed_pending = plan.typed;
    typed_value.average = plan.typed_avg;
    typed_value.channel_out = plan.last_ch;
    drive_window(plan.first_shape, plan.first_a, plan.first_b, plan.mixed,
                 plan.last_ch, tmsf_pkg::ROUNDS == 1);
    for (int w = 1; w < tmsf_pkg::ROUNDS; w++) begin
      drive_window(plan.rest_shape, plan.rest_a, plan.rest_b, plan.mixed,
                   plan.last_ch, w == tmsf_pkg::ROUNDS - 1);
    end
  endtask

  // Random window shape; cheap (nearly sorted) shapes dominate to keep runs short
  task automatic pick_shape(output win_shape_t shape, output int a, output int b);
    int roll;
    roll = $urandom_range(99);
    a = $urandom_range(SAMPLE_MAX);
    b = $urandom_range(SAMPLE_MAX);
    if (roll < 8) begin
      shape = SHAPE_BAND;
      a = 0;
      b = SAMPLE_MAX;
    end else if (roll < 14) begin
      shape = SHAPE_BAND;
      b = a + $urandom_range(255);
    end else if (roll < 16) begin
      shape = SHAPE_DESC;
      a = $urandom_range(SAMPLE_MAX / 2, SAMPLE_MAX);
      b = $urandom_range(41);
    end else if (roll < 24) begin
      shape = SHAPE_LEVELS;
    end else if (roll < 70) begin
      shape = SHAPE_RAMP;
      b = $urandom_range(41);
    end else if (roll < 85) begin
      shape = SHAPE_CONST;
    end else begin
      shape = SHAPE_SPLIT;
      b = $urandom_range(a, SAMPLE_MAX);
    end
  endtask

  task automatic drive_random_run();
    win_shape_t shape;
    int         a;
    int         b;
    bit         mixed;
    bit         last_ch;
    typed_pending = 1'b0;
    mixed = ($urandom_range(99) < 20);
    last_ch = 1'($urandom_range(1));
    for (int w = 0; w < tmsf_pkg::ROUNDS; w++) begin
      pick_shape(shape, a, b);
      drive_window(shape, a, b, mixed, last_ch, w == tmsf_pkg::ROUNDS - 1);
    end
  endtask

  // Main sequence
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed runs, no idling
    for (int i = 0; i < NUM_DIRECTED; i++) drive_run(DIRECTED_RUNS[i]);
    release_input();
    wait_drain();

    // random runs under each idling mix, draining between phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct = SRC_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];
      for (int r = 0; r < RUNS_PER_PHASE; r++) drive_random_run();
      release_input();
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0 && avg_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
